@@ hdl/gfpt_pkg.sv @@
// ----------------------------------------------------------------------------
// gfpt_pkg
// shared widths, register indexes and result type of the fixed priority tick
// scheduler
// ----------------------------------------------------------------------------
package gfpt_pkg;

    // fixed field widths
    localparam int MAX_TASKS   = 4;
    localparam int CNT_W       = 8;
    localparam int MASK_W      = MAX_TASKS;
    localparam int CORE_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int PACK_W      = MAX_TASKS * CNT_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK0      = 3'd1;

    // reset value of the core count register
    localparam logic [CORE_W-1:0] CORE_COUNT_RST = 3'd1;

    // one result per tick
    typedef struct packed {
        logic [MASK_W-1:0] ran_tasks;
        logic [MASK_W-1:0] released_tasks;
        logic [MASK_W-1:0] finished_tasks;
        logic              miss_flag;
        logic [CORE_W-1:0] busy_cores;
        logic [PACK_W-1:0] work_left;
        logic [PACK_W-1:0] deadline_left;
    } t_result;

endpackage

@@ hdl/global_fixed_priority_tick_top.sv @@
// ----------------------------------------------------------------------------
// global_fixed_priority_tick_top
// global fixed priority scheduler, one time tick per request
// ----------------------------------------------------------------------------
// Each input request is one time tick carrying a release mask. Per task the
// block holds remaining work and remaining deadline. On every tick all
// deadlines count down (saturating at zero), the first core_count tasks with
// work left, lowest index first, each run one unit, and then every requested
// task whose slot is idle at work zero and deadline zero is reloaded from its
// configured parameters, if non-zero. One tick is accepted per clock cycle
// unless the input stalls; its result goes into the output register, or the
// skid register if that is held. This two-entry output buffer keeps the
// input side moving while the output is stalled; the input only stalls once
// both entries are full. The rate is set by the combinational loop from the
// task counters through the priority prefix count and back. Configuration:
// index 0 is core_count (bits 2..0), indexes 1..4 are the task parameters,
// work in bits 15..8 and relative deadline in bits 7..0; other indexes are
// ignored. Tasks at NUM_TASKS and above read as zero in every output.
// ----------------------------------------------------------------------------
module global_fixed_priority_tick_top #(
    parameter int NUM_TASKS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [gfpt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gfpt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // tick requests
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [gfpt_pkg::MASK_W-1:0]       i_release_request,
    // results
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [gfpt_pkg::MASK_W-1:0]       o_ran_tasks,
    output logic [gfpt_pkg::MASK_W-1:0]       o_released_tasks,
    output logic [gfpt_pkg::MASK_W-1:0]       o_finished_tasks,
    output logic                              o_miss_flag,
    output logic [gfpt_pkg::CORE_W-1:0]       o_busy_cores,
    output logic [gfpt_pkg::PACK_W-1:0]       o_work_left,
    output logic [gfpt_pkg::PACK_W-1:0]       o_deadline_left
);

    // configuration registers
    logic [gfpt_pkg::CORE_W-1:0]     r_core_count;
    logic [gfpt_pkg::CFG_DATA_W-1:0] r_params [NUM_TASKS];

    // per task counters
    logic [gfpt_pkg::CNT_W-1:0] r_work [NUM_TASKS];
    logic [gfpt_pkg::CNT_W-1:0] r_dl   [NUM_TASKS];
    logic [gfpt_pkg::CNT_W-1:0] n_work [NUM_TASKS];
    logic [gfpt_pkg::CNT_W-1:0] n_dl   [NUM_TASKS];

    // output buffer
    gfpt_pkg::t_result r_out;
    gfpt_pkg::t_result r_skid;
    gfpt_pkg::t_result n_result;
    logic              r_out_valid;
    logic              r_skid_valid;

    logic in_accept;
    logic out_take;

    // input stalls only once the skid entry is occupied
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    // ------------------------------------------------------------------
    // one tick: deadline countdown and run pass in priority order, then release, then pack
    // ------------------------------------------------------------------
    always_comb begin
        logic [gfpt_pkg::CNT_W-1:0]  v_work;
        logic [gfpt_pkg::CNT_W-1:0]  v_dl;
        logic [gfpt_pkg::CNT_W-1:0]  v_pw;
        logic [gfpt_pkg::CNT_W-1:0]  v_pd;
        logic [gfpt_pkg::CORE_W-1:0] v_used;

        n_result = '0;
        v_used   = '0;
        for (int t = 0; t < NUM_TASKS; t++) begin
            v_work = r_work[t];
            // deadline saturates at zero
            v_dl   = (r_dl[t] != '0) ? r_dl[t] - 8'd1 : '0;
            // prefix count of cores already handed out
            if (v_work != '0 && v_used != r_core_count) begin
                v_work = v_work - 8'd1;
                v_used = v_used + 3'd1;
                n_result.ran_tasks[t] = 1'b1;
                if (v_work == '0) begin
                    n_result.finished_tasks[t] = 1'b1;
                end
            end
            // reload an idle slot when requested and the parameters are not empty
            v_pw = r_params[t][15:8];
            v_pd = r_params[t][7:0];
            if (i_release_request[t] && v_work == '0 && v_dl == '0 &&
                (v_pw != '0 || v_pd != '0)) begin
                v_work = v_pw;
                v_dl   = v_pd;
                n_result.released_tasks[t] = 1'b1;
            end
            if (v_work > v_dl) begin
                n_result.miss_flag = 1'b1;
            end
            n_work[t] = v_work;
            n_dl[t]   = v_dl;
            n_result.work_left[t*gfpt_pkg::CNT_W +: gfpt_pkg::CNT_W]     = v_work;
            n_result.deadline_left[t*gfpt_pkg::CNT_W +: gfpt_pkg::CNT_W] = v_dl;
        end
        n_result.busy_cores = v_used;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_count <= gfpt_pkg::CORE_COUNT_RST;
            for (int t = 0; t < NUM_TASKS; t++) begin
                r_params[t] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == gfpt_pkg::CFG_CORE_COUNT) begin
                r_core_count <= i_cfg_data[gfpt_pkg::CORE_W-1:0];
            end
            for (int t = 0; t < NUM_TASKS; t++) begin
                if (i_cfg_index == gfpt_pkg::CFG_TASK0 + 3'(t)) begin
                    r_params[t] <= i_cfg_data;
                end
            end
        end
    end

    // task counters advance on every accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TASKS; t++) begin
                r_work[t] <= '0;
                r_dl[t]   <= '0;
            end
        end else if (in_accept) begin
            for (int t = 0; t < NUM_TASKS; t++) begin
                r_work[t] <= n_work[t];
                r_dl[t]   <= n_dl[t];
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // skid entry drains into the result register
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_accept) begin
            if (r_out_valid && !out_take) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_ran_tasks      = r_out.ran_tasks;
    assign o_released_tasks = r_out.released_tasks;
    assign o_finished_tasks = r_out.finished_tasks;
    assign o_miss_flag      = r_out.miss_flag;
    assign o_busy_cores     = r_out.busy_cores;
    assign o_work_left      = r_out.work_left;
    assign o_deadline_left  = r_out.deadline_left;

endmodule

@@ hdl/gfpt_checker.sv @@
// ----------------------------------------------------------------------------
// gfpt_checker
// port level checks of the fixed priority tick scheduler
// ----------------------------------------------------------------------------
module gfpt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [gfpt_pkg::MASK_W-1:0] o_ran_tasks,
    input logic [gfpt_pkg::MASK_W-1:0] o_finished_tasks,
    input logic [gfpt_pkg::CORE_W-1:0] o_busy_cores,
    input logic [gfpt_pkg::PACK_W-1:0] o_work_left
);

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // busy core count matches the ran mask
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_busy_cores) == $countones(o_ran_tasks)))
        else $error("busy_cores does not match ran_tasks");

    // a task can only finish if it ran
    a_fin_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_finished_tasks & ~o_ran_tasks) == '0))
        else $error("finished task that did not run");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_work_left)))
        else $error("stalled result changed");

endmodule

bind global_fixed_priority_tick_top gfpt_checker u_gfpt_checker (.*);

@@ tb/sv/global_fixed_priority_tick_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// global_fixed_priority_tick_top_tb
// self-checking bench for the global fixed priority tick scheduler
// ----------------------------------------------------------------------------
// Drives tick requests carrying release masks and keeps its own copy of the
// per task work and deadline counters. Every accepted request advances that
// copy by one tick, and the resulting flags and packed counters are queued.
// Each result taken from the block is checked field by field against the
// oldest queued tick. A short directed part covers reset values, ignored
// register indexes, priority order, busy slots, zero parameters, zero and
// oversized core counts and finish-with-reload. Random phases with fresh
// register settings follow, under changing idle patterns on both sides, a
// pause until the block has drained and a long output hold-off.
// ----------------------------------------------------------------------------
module global_fixed_priority_tick_top_tb;

    localparam int CLK_PERIOD  = 10;
    localparam int NUM_TASKS   = 4;
    localparam int HOLD_CYCLES = 60;
    localparam int PRINT_LIMIT = 200;
    localparam int SLOT_W      = $clog2(gfpt_pkg::MAX_TASKS);

    // first register index past the task parameters, writes there are dropped
    localparam logic [gfpt_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST =
        gfpt_pkg::CFG_TASK0 + 3'(gfpt_pkg::MAX_TASKS);

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [gfpt_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [gfpt_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic [gfpt_pkg::MASK_W-1:0]     i_release_request;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic [gfpt_pkg::MASK_W-1:0]     o_ran_tasks;
    logic [gfpt_pkg::MASK_W-1:0]     o_released_tasks;
    logic [gfpt_pkg::MASK_W-1:0]     o_finished_tasks;
    logic                            o_miss_flag;
    logic [gfpt_pkg::CORE_W-1:0]     o_busy_cores;
    logic [gfpt_pkg::PACK_W-1:0]     o_work_left;
    logic [gfpt_pkg::PACK_W-1:0]     o_deadline_left;

    // scheduler state as the bench sees it
    logic [gfpt_pkg::CORE_W-1:0]     core_limit;
    logic [gfpt_pkg::CFG_DATA_W-1:0] task_cfg [gfpt_pkg::MAX_TASKS];
    logic [gfpt_pkg::CNT_W-1:0]      work_cnt [gfpt_pkg::MAX_TASKS];
    logic [gfpt_pkg::CNT_W-1:0]      deadline_cnt [gfpt_pkg::MAX_TASKS];

    // results owed by the block, oldest first
    gfpt_pkg::t_result pending_results [$];

    int mismatch_count = 0;
    int send_idle_pct  = 33;
    int recv_idle_pct  = 71;
    // bumped by a test to start a long output hold-off, only the bench writes it
    int hold_requests  = 0;

    global_fixed_priority_tick_top #(
        .NUM_TASKS (NUM_TASKS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_release_request (i_release_request),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_ran_tasks       (o_ran_tasks),
        .o_released_tasks  (o_released_tasks),
        .o_finished_tasks  (o_finished_tasks),
        .o_miss_flag       (o_miss_flag),
        .o_busy_cores      (o_busy_cores),
        .o_work_left       (o_work_left),
        .o_deadline_left   (o_deadline_left)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // register index of the parameters of task t
    function automatic logic [gfpt_pkg::CFG_IDX_W-1:0] task_reg(input int t);
        return gfpt_pkg::CFG_TASK0 + t[gfpt_pkg::CFG_IDX_W-1:0];
    endfunction

    // one scheduler tick: countdown and priority run pass, then the release pass
    function automatic gfpt_pkg::t_result advance_tick(
        input logic [gfpt_pkg::MASK_W-1:0] mask);
        gfpt_pkg::t_result r;
        int                used;
        r    = '0;
        used = 0;
        for (int t = 0; t < NUM_TASKS; t++) begin
            // deadlines always count down, saturating at zero
            if (deadline_cnt[t] != 0)
                deadline_cnt[t] = deadline_cnt[t] - 1'b1;
            // lowest index first takes a free core
            if (work_cnt[t] != 0 && used != core_limit) begin
                work_cnt[t] = work_cnt[t] - 1'b1;
                used++;
                r.ran_tasks[t] = 1'b1;
                if (work_cnt[t] == 0)
                    r.finished_tasks[t] = 1'b1;
            end
        end
        for (int t = 0; t < NUM_TASKS; t++) begin
            // reload only an idle slot, and only with non-zero parameters
            if (mask[t] && work_cnt[t] == 0 && deadline_cnt[t] == 0 && task_cfg[t] != 0) begin
                work_cnt[t]     = task_cfg[t][15:8];
                deadline_cnt[t] = task_cfg[t][7:0];
                r.released_tasks[t] = 1'b1;
            end
        end
        for (int t = 0; t < NUM_TASKS; t++) begin
            if (work_cnt[t] > deadline_cnt[t])
                r.miss_flag = 1'b1;
            r.work_left[gfpt_pkg::CNT_W*t +: gfpt_pkg::CNT_W]     = work_cnt[t];
            r.deadline_left[gfpt_pkg::CNT_W*t +: gfpt_pkg::CNT_W] = deadline_cnt[t];
        end
        r.busy_cores = used[gfpt_pkg::CORE_W-1:0];
        return r;
    endfunction

    // mostly random masks, with empty, full and single-task ones mixed in
    function automatic logic [gfpt_pkg::MASK_W-1:0] pick_mask();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return gfpt_pkg::MASK_W'(1) << $urandom_range(gfpt_pkg::MASK_W - 1);
            default: return gfpt_pkg::MASK_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        // keep the log readable if the block is badly broken
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // register write, only called while no request is in flight
    task automatic write_reg(input logic [gfpt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gfpt_pkg::CFG_DATA_W-1:0] data);
        logic [gfpt_pkg::CFG_IDX_W-1:0] slot;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        slot = idx - gfpt_pkg::CFG_TASK0;
        if (idx == gfpt_pkg::CFG_CORE_COUNT)
            core_limit = data[gfpt_pkg::CORE_W-1:0];
        else if (idx >= gfpt_pkg::CFG_TASK0 && idx < CFG_SPARE_FIRST)
            task_cfg[slot[SLOT_W-1:0]] = data;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one tick request, with random gaps ahead of it, and wait for it to go in
    task automatic send_tick(input logic [gfpt_pkg::MASK_W-1:0] mask);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_release_request <= mask;
        do
            @(posedge i_clk);
        while (o_in_stall);
        // accepted at this edge, so the tick happens now
        pending_results = {pending_results, advance_tick(mask)};
    endtask

    // stop offering and wait until every owed result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // reset values: one core, all parameters zero, so nothing can be loaded
    task automatic test_reset_state();
        send_tick('0);
        send_tick('1);
    endtask

    // indexes past the task parameters must change nothing
    task automatic test_spare_registers();
        drain_results();
        for (int r = CFG_SPARE_FIRST; r < (1 << gfpt_pkg::CFG_IDX_W); r++)
            write_reg(r[gfpt_pkg::CFG_IDX_W-1:0], '1);
        send_tick('1);
    endtask

    // one core in priority order, busy slots ignored, one task left unconfigured
    task automatic test_priority_order();
        drain_results();
        write_reg(gfpt_pkg::CFG_CORE_COUNT, 16'd1);
        write_reg(task_reg(0), 16'h0203);
        write_reg(task_reg(1), 16'h0104);
        // more work than deadline, flags a miss straight away
        write_reg(task_reg(2), 16'h0302);
        write_reg(task_reg(3), 16'h0000);
        send_tick('1);
        send_tick('1);
        send_tick('1);
        send_tick('0);
        send_tick('1);
        send_tick('0);
    endtask

    // no cores at all, then more cores than tasks
    task automatic test_core_extremes();
        drain_results();
        write_reg(gfpt_pkg::CFG_CORE_COUNT, 16'd0);
        send_tick('1);
        send_tick('1);
        drain_results();
        write_reg(gfpt_pkg::CFG_CORE_COUNT, 16'd7);
        repeat (3) send_tick('1);
    endtask

    // single unit jobs finish and reload in the same tick, largest job alongside
    task automatic test_finish_and_release();
        drain_results();
        write_reg(gfpt_pkg::CFG_CORE_COUNT, 16'd4);
        write_reg(task_reg(0), 16'h0101);
        write_reg(task_reg(1), 16'h0101);
        write_reg(task_reg(2), 16'hFFFF);
        write_reg(task_reg(3), 16'h0201);
        repeat (5) send_tick('1);
    endtask

    // fresh settings, then a run of random ticks
    task automatic test_random_phase(input int ticks,
                                     input logic [gfpt_pkg::CORE_W-1:0] cores);
        logic [gfpt_pkg::CFG_DATA_W-1:0] params;
        drain_results();
        write_reg(gfpt_pkg::CFG_CORE_COUNT, gfpt_pkg::CFG_DATA_W'(cores));
        for (int t = 0; t < gfpt_pkg::MAX_TASKS; t++) begin
            case ($urandom_range(9))
                0:       params = gfpt_pkg::CFG_DATA_W'($urandom);
                1:       params = '0;
                // overloaded jobs that miss their deadline
                2:       params = {8'($urandom_range(4, 9)), 8'($urandom_range(0, 3))};
                // short jobs so that slots keep coming free
                default: params = {8'($urandom_range(1, 5)), 8'($urandom_range(1, 8))};
            endcase
            write_reg(task_reg(t), params);
        end
        repeat (ticks) send_tick(pick_mask());
    endtask

    // sender stops until everything owed has arrived, then carries on
    task automatic test_pause_and_drain();
        repeat (20) send_tick(pick_mask());
        drain_results();
        repeat (20) send_tick(pick_mask());
    endtask

    // output held off for a long stretch while requests keep coming
    task automatic test_long_hold();
        hold_requests++;
        repeat (40) send_tick(pick_mask());
    endtask

    // result side stall, random or a counted hold-off when one is asked for
    initial begin : result_stall_gen
        int holds_done;
        int hold_left;
        holds_done  = 0;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // every taken result against the oldest owed one
    always @(posedge i_clk) begin : result_check
        gfpt_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no tick pending", '0, 32'(o_ran_tasks));
            end else begin
                want = pending_results.pop_front();
                if (o_ran_tasks !== want.ran_tasks)
                    report_mismatch("ran_tasks", 32'(want.ran_tasks), 32'(o_ran_tasks));
                if (o_released_tasks !== want.released_tasks)
                    report_mismatch("released_tasks", 32'(want.released_tasks),
                                    32'(o_released_tasks));
                if (o_finished_tasks !== want.finished_tasks)
                    report_mismatch("finished_tasks", 32'(want.finished_tasks),
                                    32'(o_finished_tasks));
                if (o_miss_flag !== want.miss_flag)
                    report_mismatch("miss_flag", 32'(want.miss_flag), 32'(o_miss_flag));
                if (o_busy_cores !== want.busy_cores)
                    report_mismatch("busy_cores", 32'(want.busy_cores), 32'(o_busy_cores));
                if (o_work_left !== want.work_left)
                    report_mismatch("work_left", want.work_left, o_work_left);
                if (o_deadline_left !== want.deadline_left)
                    report_mismatch("deadline_left", want.deadline_left, o_deadline_left);
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_release_request = '0;
        core_limit        = gfpt_pkg::CORE_COUNT_RST;
        for (int t = 0; t < gfpt_pkg::MAX_TASKS; t++) begin
            task_cfg[t]     = '0;
            work_cnt[t]     = '0;
            deadline_cnt[t] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles a third of the time, receiver most of the time
        send_idle_pct = 33;
        recv_idle_pct = 71;
        test_reset_state();
        test_spare_registers();
        test_priority_order();
        test_core_extremes();
        test_finish_and_release();
        test_random_phase(95, 3'd4);
        test_random_phase(95, 3'd3);

        // the other way round
        send_idle_pct = 71;
        recv_idle_pct = 33;
        test_random_phase(95, 3'd2);
        test_pause_and_drain();
        test_random_phase(95, gfpt_pkg::CORE_W'($urandom_range(7)));

        // back to back on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_long_hold();
        test_random_phase(95, 3'd1);

        drain_results();
        // room for any stray result to show up
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // overall guard against a hung handshake
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/gfpt_pkg.sv
hdl/global_fixed_priority_tick_top.sv
hdl/gfpt_checker.sv
tb/sv/global_fixed_priority_tick_top_tb.sv
